// ===== rtl/core/cqr_pkg.sv =====
// Shared types and constants for the circular queue with readout.
// Used by cqr_ctrl, cqr_datapath and circular_queue_with_readout_core.
`default_nettype none

package cqr_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int WORD_W    = 32;
	localparam int MODE_W    = 2;
	localparam int STATUS_W  = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READOUT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic                load_code;  // load a word-less result with code
		logic [STATUS_W-1:0] code;
		logic                push;       // write item into ring at tail
		logic                begin_dump; // latch head, start first ring read
		logic                single;     // dump only the oldest word
		logic                pop;        // advance head, drop one word
		logic                emit;       // move read word into output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic out_free;
		logic final_word;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cqr_ctrl.sv =====
// Request sequencer for the circular queue: idle decode and word dump.
// Depends on cqr_pkg for command/status structs and codes.
`default_nettype none

module cqr_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	input  wire logic [cqr_pkg::MODE_W-1:0]  mode,
	output logic                             req_stall,
	input  wire cqr_pkg::sts_t               sts,
	output cqr_pkg::cmd_t                    cmd
);

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t state_q;
	logic   accept;

	assign req_stall = !((state_q == S_IDLE) && sts.out_free);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		cmd = '0;
		cmd.code = cqr_pkg::ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode)
						cqr_pkg::MODE_INSERT: begin
							cmd.load_code = 1'b1;
							if (sts.full) begin
								cmd.code = cqr_pkg::ST_FULL;
							end else begin
								cmd.push = 1'b1;
							end
						end
						cqr_pkg::MODE_REMOVE: begin
							if (sts.empty) begin
								cmd.load_code = 1'b1;
								cmd.code      = cqr_pkg::ST_EMPTY;
							end else begin
								cmd.begin_dump = 1'b1;
								cmd.single     = 1'b1;
								cmd.pop        = 1'b1;
							end
						end
						cqr_pkg::MODE_READOUT: begin
							if (sts.empty) begin
								cmd.load_code = 1'b1;
								cmd.code      = cqr_pkg::ST_EMPTY;
							end else begin
								cmd.begin_dump = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_DUMP: begin
				cmd.emit = sts.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.begin_dump) begin
						state_q <= S_DUMP;
					end
				end
				S_DUMP: begin
					if (sts.out_free && sts.final_word) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/cqr_datapath.sv =====
// Ring memory, head/tail pointers, occupancy, dump cursor and output register.
// Depends on cqr_pkg; driven by cqr_ctrl commands.
`default_nettype none

module cqr_datapath #(
	parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire cqr_pkg::cmd_t                      cmd,
	output cqr_pkg::sts_t                           sts,
	input  wire logic signed [cqr_pkg::WORD_W-1:0]  push_value,
	input  wire logic                               rsp_stall,
	output logic                                    rsp_valid,
	output logic [cqr_pkg::STATUS_W-1:0]            status,
	output logic signed [cqr_pkg::WORD_W-1:0]       word_out,
	output logic                                    last
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	function automatic logic [PTR_W-1:0] next_idx(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

	logic signed [cqr_pkg::WORD_W-1:0] ring_q [DEPTH];
	logic signed [cqr_pkg::WORD_W-1:0] rd_data_q;

	logic [PTR_W-1:0] head_q;
	logic [PTR_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] idx_q;
	logic [CNT_W-1:0] remain_q;

	logic                              rsp_valid_q;
	logic [cqr_pkg::STATUS_W-1:0]      status_q;
	logic signed [cqr_pkg::WORD_W-1:0] word_q;
	logic                              last_q;

	logic             rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic             final_word;

	assign final_word = (remain_q == CNT_W'(1));
	assign rd_en      = cmd.begin_dump || (cmd.emit && !final_word);
	assign rd_addr    = cmd.begin_dump ? head_q : next_idx(idx_q);

	assign sts.empty      = (count_q == '0);
	assign sts.full       = (count_q == CNT_W'(DEPTH));
	assign sts.out_free   = !rsp_valid_q || !rsp_stall;
	assign sts.final_word = final_word;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ring_q[tail_q] <= push_value;
		end
		if (rd_en) begin
			rd_data_q <= ring_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			remain_q <= '0;
		end else begin
			if (cmd.push) begin
				tail_q  <= next_idx(tail_q);
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.pop) begin
				head_q  <= next_idx(head_q);
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.begin_dump) begin
				idx_q    <= head_q;
				remain_q <= cmd.single ? CNT_W'(1) : count_q;
			end else if (cmd.emit) begin
				idx_q    <= next_idx(idx_q);
				remain_q <= remain_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_code || cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_code) begin
			status_q <= cmd.code;
			word_q   <= '0;
			last_q   <= 1'b1;
		end else if (cmd.emit) begin
			status_q <= cqr_pkg::ST_OK;
			word_q   <= rd_data_q;
			last_q   <= final_word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign word_out  = word_q;
	assign last      = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/circular_queue_with_readout_core.sv =====
// Circular queue with readout: insert, remove-oldest and full readout.
// Insert and any refused or empty request give their item in the cycle after acceptance; a
// remove or readout moves each word through the registered ring read port, then the output
// register, and a readout gives its words one a cycle while rsp_stall is low. No request is
// taken until a remove or readout has emitted its last word.
// Reset clears pointers, occupancy and the sequencer; ring contents stay undefined.
`default_nettype none

module circular_queue_with_readout_core #(
	parameter int DEPTH = cqr_pkg::DEPTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire logic [cqr_pkg::MODE_W-1:0]         mode,
	input  wire logic signed [cqr_pkg::WORD_W-1:0]  push_value,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output logic [cqr_pkg::STATUS_W-1:0]            status,
	output logic signed [cqr_pkg::WORD_W-1:0]       word_out,
	output logic                                    last
);

	cqr_pkg::cmd_t cmd;
	cqr_pkg::sts_t sts;

	cqr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.mode      (mode),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	cqr_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.push_value (push_value),
		.rsp_stall  (rsp_stall),
		.rsp_valid  (rsp_valid),
		.status     (status),
		.word_out   (word_out),
		.last       (last)
	);

	a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> req_stall)
		else $error("request accepted during word dump");

	a_insert_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && mode == cqr_pkg::MODE_INSERT) |=> (rsp_valid && last))
		else $error("insert gave no single result");

	a_empty_readout: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && mode == cqr_pkg::MODE_READOUT && sts.empty)
		|=> (rsp_valid && status == cqr_pkg::ST_EMPTY && last))
		else $error("readout of empty queue not reported");

	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(sts.full && sts.empty))
		else $error("occupancy both full and empty");

endmodule

`default_nettype wire

// ===== verif/circular_queue_with_readout_core_test.sv =====
// Self-checking testbench for circular_queue_with_readout_core: a directed table, then random
// insert/remove/readout traffic, checked against an in-bench queue predictor.
// Depends on cqr_pkg and the core RTL only.
`default_nettype none

module circular_queue_with_readout_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = cqr_pkg::DEPTH_DEF;
	localparam logic [cqr_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 175;
	localparam int STUCK_LIMIT = 2000;
	localparam int LONG_HOLD = 120;

	typedef struct packed {
		logic [cqr_pkg::STATUS_W-1:0]      status;
		logic signed [cqr_pkg::WORD_W-1:0] word;
		logic                              last;
	} result_t;

	typedef struct packed {
		logic [cqr_pkg::MODE_W-1:0]        op;
		logic signed [cqr_pkg::WORD_W-1:0] val;
		logic                              typed;
		logic [cqr_pkg::STATUS_W-1:0]      st;
	} row_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              req_valid = 1'b0;
	logic                              req_stall;
	logic [cqr_pkg::MODE_W-1:0]        mode = '0;
	logic signed [cqr_pkg::WORD_W-1:0] push_value = '0;
	logic                              rsp_valid;
	logic                              rsp_stall = 1'b0;
	logic [cqr_pkg::STATUS_W-1:0]      status;
	logic signed [cqr_pkg::WORD_W-1:0] word_out;
	logic                              last;

	// predictor state
	logic signed [cqr_pkg::WORD_W-1:0] ring_words [DEPTH];
	int                                head_idx = 0;
	int                                tail_idx = 0;
	int                                fill_count = 0;

	result_t pending_results [$];
	int      error_count = 0;
	int      stuck_cycles = 0;
	bit      idle_on = 1'b1;
	bit      hold_request = 1'b0;

	circular_queue_with_readout_core #(.DEPTH(DEPTH)) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.mode       (mode),
		.push_value (push_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.word_out   (word_out),
		.last       (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic queue_step(input logic [cqr_pkg::MODE_W-1:0] op,
			input logic signed [cqr_pkg::WORD_W-1:0] val, ref result_t outq [$]);
		result_t r;
		int idx;
		r = '{status: cqr_pkg::ST_OK, word: '0, last: 1'b1};
		case (op)
		cqr_pkg::MODE_INSERT: begin
			if (fill_count == DEPTH) begin
				r.status = cqr_pkg::ST_FULL;
			end else begin
				ring_words[tail_idx] = val;
				tail_idx = (tail_idx + 1) % DEPTH;
				fill_count++;
			end
			outq.push_back(r);
		end
		cqr_pkg::MODE_REMOVE: begin
			if (fill_count == 0) begin
				r.status = cqr_pkg::ST_EMPTY;
			end else begin
				r.word = ring_words[head_idx];
				head_idx = (head_idx + 1) % DEPTH;
				fill_count--;
			end
			outq.push_back(r);
		end
		cqr_pkg::MODE_READOUT: begin
			if (fill_count == 0) begin
				r.status = cqr_pkg::ST_EMPTY;
				outq.push_back(r);
			end else begin
				idx = head_idx;
				for (int k = 0; k < fill_count; k++) begin
					r.word = ring_words[idx];
					r.last = (k == fill_count - 1);
					outq.push_back(r);
					idx = (idx + 1) % DEPTH;
				end
			end
		end
		default: ;
		endcase
	endtask

	task automatic offer(input logic [cqr_pkg::MODE_W-1:0] op,
			input logic signed [cqr_pkg::WORD_W-1:0] val,
			input logic typed, input logic [cqr_pkg::STATUS_W-1:0] typed_status);
		result_t step_results [$];
		@(negedge clk);
		req_valid <= 1'b1;
		mode <= op;
		push_value <= val;
		do @(posedge clk); while (req_stall);
		queue_step(op, val, step_results);
		if (typed)
			pending_results.push_back('{status: typed_status, word: '0, last: 1'b1});
		else
			foreach (step_results[i]) pending_results.push_back(step_results[i]);
	endtask

	task automatic pause_sender(input int n);
		@(negedge clk);
		req_valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// response checker
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected item: status %0d word %0d last %0d",
					status, word_out, last));
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status || word_out !== want.word || last !== want.last)
					note_error($sformatf(
						"status exp %0d got %0d, word exp %0d got %0d, last exp %0d got %0d",
						want.status, status, want.word, word_out, want.last, last));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver back-pressure
	initial begin
		int burst;
		burst = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				rsp_stall <= 1'b1;
				repeat (LONG_HOLD) @(negedge clk);
				rsp_stall <= 1'b0;
			end else if (burst > 0 && idle_on) begin
				burst--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				burst = $urandom_range(0, 17);
			end else begin
				rsp_stall <= 1'b0;
				burst = 0;
			end
		end
	end

	initial begin
		row_t directed_rows [22];
		int counted;
		int roll;
		bit filling;
		logic [cqr_pkg::MODE_W-1:0] op;
		logic signed [cqr_pkg::WORD_W-1:0] val;

		directed_rows = '{
			'{cqr_pkg::MODE_REMOVE,  32'sh00000000, 1'b1, cqr_pkg::ST_EMPTY},
			'{cqr_pkg::MODE_READOUT, 32'sh00000000, 1'b1, cqr_pkg::ST_EMPTY},
			'{MODE_UNUSED,           32'shFFFFFFFF, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh7FFFFFFF, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh80000000, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh00000000, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'shFFFFFFFF, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh00000001, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh55555555, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'shAAAAAAAA, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh12345678, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh0BADF00D, 1'b1, cqr_pkg::ST_FULL},
			'{cqr_pkg::MODE_READOUT, 32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_REMOVE,  32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'shDEADBEEF, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_READOUT, 32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{MODE_UNUSED,           32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_REMOVE,  32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_REMOVE,  32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_READOUT, 32'sh00000000, 1'b0, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_INSERT,  32'sh00000002, 1'b1, cqr_pkg::ST_OK},
			'{cqr_pkg::MODE_READOUT, 32'sh00000000, 1'b0, cqr_pkg::ST_OK}
		};
		counted = 0;
		filling = 1'b1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			offer(directed_rows[i].op, directed_rows[i].val, directed_rows[i].typed,
				directed_rows[i].st);
			if (idle_on && $urandom_range(0, 3) == 0)
				pause_sender($urandom_range(1, 18));
		end

		while (counted < RANDOM_ITEMS) begin
			if (counted % 25 == 0) begin
				filling = ~filling;
				idle_on = ($urandom_range(0, 3) != 0);
			end
			if (counted == 90) begin
				hold_request = 1'b1;
				idle_on = 1'b0;
			end
			if (counted == 140) begin
				pause_sender(1);
				while (pending_results.size() != 0) @(posedge clk);
			end
			if (counted >= RANDOM_ITEMS - 30)
				idle_on = 1'b0;

			roll = $urandom_range(0, 99);
			if (roll >= 95)
				op = MODE_UNUSED;
			else if (roll < (filling ? 60 : 20))
				op = cqr_pkg::MODE_INSERT;
			else if (roll < (filling ? 80 : 65))
				op = cqr_pkg::MODE_REMOVE;
			else
				op = cqr_pkg::MODE_READOUT;

			case ($urandom_range(0, 11))
			0: val = 32'sh7FFFFFFF;
			1: val = 32'sh80000000;
			2: val = '0;
			3: val = -1;
			default: val = $urandom;
			endcase

			offer(op, val, 1'b0, cqr_pkg::ST_OK);
			if (op != MODE_UNUSED)
				counted++;
			if (idle_on && $urandom_range(0, 4) == 0)
				pause_sender($urandom_range(1, 18));
		end

		pause_sender(1);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4 * DEPTH) @(posedge clk);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
